[hw/rtl/tsq_pkg.sv]
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types, constants and codes for the two-stack FIFO queue.
// ----------------------------------------------------------------------------
package tsq_pkg;

   localparam int DEPTH  = 128;
   localparam int DATA_W = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic                     cmd;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [1:0]               status;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOVE,
      S_READ
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic enq;        // push request value onto input stack
      logic rsp_full;   // return full status
      logic rsp_empty;  // return empty status
      logic mv_rd;      // read top of input stack, pop it
      logic out_rd;     // read top of output stack, pop it
      logic out_ld;     // return output stack read data
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_empty;
      logic in_full;
      logic out_empty;
      logic mv_pend;
      logic slot_free;
   } ctl_stat_type;

endpackage

[hw/rtl/two_stack_fifo_queue.sv]
// ----------------------------------------------------------------------------
// two_stack_fifo_queue
// First-in first-out queue built from an input stack and an output stack.
// ----------------------------------------------------------------------------
// An enqueue writes the input stack and loads its result from S_IDLE. A
// dequeue from a non-empty output stack pops it in S_IDLE and loads the
// registered read data of the stack memory into the result in S_READ. A
// dequeue that finds the output stack empty first moves all N input entries
// across in S_MOVE, one per cycle through the single read port of the input
// stack, then reads the output stack; every entry crosses only once. A full
// input stack drops the enqueue and reports full; a dequeue on an empty queue
// reports empty with zero data. Each item gives one result, held in an output
// register; no new item is taken while a result waits under stall.
module two_stack_fifo_queue import tsq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   ctl_cmd_type  ctl_cmd;
   ctl_stat_type ctl_stat;

   tsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_payload.cmd),
      .ctl_stat  (ctl_stat),
      .ctl_cmd   (ctl_cmd)
   );

   tsq_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctl_cmd     (ctl_cmd),
      .ctl_stat    (ctl_stat),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[hw/rtl/tsq_ram.sv]
// ----------------------------------------------------------------------------
// tsq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tsq_dpath.sv]
// ----------------------------------------------------------------------------
// tsq_dpath
// Stack memories, stack counts, transfer write-back and result register.
// ----------------------------------------------------------------------------
module tsq_dpath import tsq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ctl_cmd_type  ctl_cmd,
   output ctl_stat_type ctl_stat,
   input  req_type      req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_payload
);

   logic [CNT_W-1:0]  in_count_ff,  in_count_in;
   logic [CNT_W-1:0]  out_count_ff, out_count_in;
   logic              mv_pend_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   logic [CNT_W-1:0]  in_dec;
   logic [CNT_W-1:0]  out_dec;
   logic [DATA_W-1:0] in_rd_data;
   logic [DATA_W-1:0] out_rd_data;
   logic              rsp_load;

   assign in_dec  = in_count_ff - 1'b1;
   assign out_dec = out_count_ff - 1'b1;

   tsq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_in_ram (
      .clock   (clock),
      .wr_en   (ctl_cmd.enq),
      .wr_addr (in_count_ff[ADDR_W-1:0]),
      .wr_data (req_payload.value),
      .rd_en   (ctl_cmd.mv_rd),
      .rd_addr (in_dec[ADDR_W-1:0]),
      .rd_data (in_rd_data)
   );

   tsq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_out_ram (
      .clock   (clock),
      .wr_en   (mv_pend_ff),
      .wr_addr (out_count_ff[ADDR_W-1:0]),
      .wr_data (in_rd_data),
      .rd_en   (ctl_cmd.out_rd),
      .rd_addr (out_dec[ADDR_W-1:0]),
      .rd_data (out_rd_data)
   );

   always_comb begin
      in_count_in = in_count_ff;
      if (ctl_cmd.enq) begin
         in_count_in = in_count_ff + 1'b1;
      end else if (ctl_cmd.mv_rd) begin
         in_count_in = in_dec;
      end
   end

   always_comb begin
      out_count_in = out_count_ff;
      if (mv_pend_ff) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (ctl_cmd.out_rd) begin
         out_count_in = out_dec;
      end
   end

   assign rsp_load = ctl_cmd.enq | ctl_cmd.rsp_full | ctl_cmd.rsp_empty | ctl_cmd.out_ld;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         rsp_valid_in          = 1'b1;
         rsp_payload_in.data   = '0;
         rsp_payload_in.status = STAT_OK;
         if (ctl_cmd.rsp_full) begin
            rsp_payload_in.status = STAT_FULL;
         end else if (ctl_cmd.rsp_empty) begin
            rsp_payload_in.status = STAT_EMPTY;
         end else if (ctl_cmd.out_ld) begin
            rsp_payload_in.data = out_rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= '0;
         out_count_ff <= '0;
         mv_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         mv_pend_ff   <= ctl_cmd.mv_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign ctl_stat.in_empty  = (in_count_ff == '0);
   assign ctl_stat.in_full   = (in_count_ff == CNT_W'(DEPTH));
   assign ctl_stat.out_empty = (out_count_ff == '0);
   assign ctl_stat.mv_pend   = mv_pend_ff;
   assign ctl_stat.slot_free = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_in_bound: assert property (@(posedge clock) disable iff (reset)
      in_count_ff <= CNT_W'(DEPTH))
      else $error("input stack count beyond depth");

   a_out_wr_room: assert property (@(posedge clock) disable iff (reset)
      mv_pend_ff |-> (out_count_ff < CNT_W'(DEPTH)))
      else $error("transfer write into full output stack");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> ctl_stat.slot_free)
      else $error("result register overwritten while held");

   a_out_pop_legal: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.out_rd |-> !ctl_stat.out_empty)
      else $error("pop from empty output stack");

   a_in_pop_legal: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.mv_rd |-> !ctl_stat.in_empty)
      else $error("pop from empty input stack");

endmodule

[hw/rtl/tsq_ctrl.sv]
// ----------------------------------------------------------------------------
// tsq_ctrl
// Controller: request decode, stack transfer sequencing and pop timing.
// ----------------------------------------------------------------------------
module tsq_ctrl import tsq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_cmd,
   input  ctl_stat_type ctl_stat,
   output ctl_cmd_type  ctl_cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = !((state_ff == S_IDLE) && ctl_stat.slot_free);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_cmd == CMD_DEQ)) begin
               if (!ctl_stat.out_empty) begin
                  state_in = S_READ;
               end else if (!ctl_stat.in_empty) begin
                  state_in = S_MOVE;
               end
            end
         end
         S_MOVE: begin
            if (ctl_stat.in_empty && !ctl_stat.mv_pend) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl_cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_ENQ) begin
                  ctl_cmd.enq      = ~ctl_stat.in_full;
                  ctl_cmd.rsp_full = ctl_stat.in_full;
               end else if (!ctl_stat.out_empty) begin
                  ctl_cmd.out_rd = 1'b1;
               end else if (ctl_stat.in_empty) begin
                  ctl_cmd.rsp_empty = 1'b1;
               end
            end
         end
         S_MOVE: begin
            ctl_cmd.mv_rd  = ~ctl_stat.in_empty;
            ctl_cmd.out_rd = ctl_stat.in_empty & ~ctl_stat.mv_pend;
         end
         S_READ: begin
            ctl_cmd.out_ld = 1'b1;
         end
         default: begin
            ctl_cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
